// ===== hw/rtl/rsif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsif_pkg
// Shared types, constants and helpers for the relay scheduler with
// interval fallback.
// ----------------------------------------------------------------------------
package rsif_pkg;

   localparam int NUM_TIMERS = 4;
   localparam int TIMER_W    = 12;
   localparam int TABLE_W    = 48;
   localparam int MAX_ON_W   = 11;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int DAY_MIN    = 1440;
   localparam int MUL_A_W    = 11;
   localparam int MUL_B_W    = 16;

   localparam logic [31:0]         GUARD_MS      = 32'd60000;
   localparam logic [31:0]         GRACE_MS      = 32'd900000;
   localparam logic [MUL_B_W-1:0]  MS_PER_MIN    = 16'd60000;
   localparam logic [MUL_B_W-1:0]  SEC_PER_MIN   = 16'd60;
   localparam logic [MAX_ON_W-1:0] ASSUMED_BLOCK = 11'd120;
   localparam logic [MAX_ON_W-1:0] MIN_OFF       = 11'd30;

   // minutes of the day per enabled timer, for one to five timers
   localparam logic [MAX_ON_W-1:0] DAY_QUOTA [1:5] = '{
      MAX_ON_W'(DAY_MIN / 1),
      MAX_ON_W'(DAY_MIN / 2),
      MAX_ON_W'(DAY_MIN / 3),
      MAX_ON_W'(DAY_MIN / 4),
      MAX_ON_W'(DAY_MIN / 5)
   };

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TABLE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMERS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ON   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK = 2'd2;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_OFF  = 2'd1;
   localparam logic [1:0] CMD_ON   = 2'd2;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_LOST   = 2'd1;
   localparam logic [1:0] EVT_RESUME = 2'd2;

   typedef struct packed {
      logic        clock_valid;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [8:0]  day_of_year;
      logic [31:0] now_ms;
      logic        relay_on;
      logic [31:0] on_seconds;
      logic        cutoff_valid;
      logic [31:0] cutoff_ms;
   } rsif_req_type;

   typedef struct packed {
      logic [1:0] relay_cmd;
      logic       timer_fired;
      logic [1:0] mode_event;
      logic       interval_mode;
   } rsif_rsp_type;

   typedef struct packed {
      logic [TABLE_W-1:0]  timer_table;
      logic [MAX_ON_W-1:0] max_on_minutes;
      logic                fallback_enabled;
   } rsif_csr_type;

   typedef struct packed {
      logic        issue;
      logic        mul;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } rsif_op_type;

   typedef struct packed {
      logic [31:0] value;
      logic        ge;
   } rsif_res_type;

   typedef struct packed {
      logic       en;
      logic [4:0] hour;
      logic [5:0] minute;
   } rsif_timer_type;

   function automatic rsif_timer_type timer_field(input logic [TABLE_W-1:0] tbl,
                                                  input int idx);
      timer_field = TIMER_W'(tbl >> (idx * TIMER_W));
   endfunction

   // minutes of the day per enabled timer
   function automatic logic [MAX_ON_W-1:0] day_quota(input logic [CNT_W-1:0] n);
      day_quota = '0;
      for (int k = 1; k <= NUM_TIMERS; k++) begin
         if (n == CNT_W'(k)) begin
            day_quota = DAY_QUOTA[k];
         end
      end
   endfunction

endpackage

// ===== hw/rtl/rsif_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsif_unit
// Shared arithmetic unit: narrow multiply, or wraparound subtract with an
// unsigned compare against a threshold. Result registered.
// ----------------------------------------------------------------------------
module rsif_unit (
   input  logic                 clock,
   input  rsif_pkg::rsif_op_type  op,
   output rsif_pkg::rsif_res_type res
);
   import rsif_pkg::*;

   logic [MUL_A_W+MUL_B_W-1:0] prod;
   logic [31:0]                diff;
   rsif_res_type               res_ff;
   rsif_res_type               res_in;

   assign prod = op.a[MUL_A_W-1:0] * op.b[MUL_B_W-1:0];
   assign diff = op.a - op.b;

   always_comb begin
      if (op.mul) begin
         res_in.value = {{(32 - MUL_A_W - MUL_B_W){1'b0}}, prod};
         res_in.ge    = 1'b0;
      end else begin
         res_in.value = diff;
         res_in.ge    = (diff >= op.c);
      end
   end

   always_ff @(posedge clock) begin
      if (op.issue) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/rsif_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsif_ctrl
// Sequencer and scheduler state: steps the shared unit through the grace,
// duty and guard checks, then decides the relay command for the tick.
// ----------------------------------------------------------------------------
module rsif_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  rsif_pkg::rsif_req_type req,
   input  rsif_pkg::rsif_csr_type csr,
   input  logic                   out_free,
   output logic                   busy,
   output logic                   done,
   output rsif_pkg::rsif_rsp_type rsp,
   output rsif_pkg::rsif_op_type  op,
   input  rsif_pkg::rsif_res_type res
);
   import rsif_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GRACE = 3'd1;
   localparam logic [2:0] ST_MOFF  = 3'd2;
   localparam logic [2:0] ST_MBLK  = 3'd3;
   localparam logic [2:0] ST_OFFC  = 3'd4;
   localparam logic [2:0] ST_CUT   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]   state_ff, state_in;
   rsif_req_type item_ff;
   logic         started_ff;
   logic [31:0]  boot_ff;
   logic         prev_ff;
   logic [31:0]  off_since_ff;
   logic         fb_ff, fb_in;
   logic [4:0]   fired_hour_ff;
   logic [5:0]   fired_minute_ff;
   logic [8:0]   fired_day_ff;
   logic         grace_ok_ff;
   logic [31:0]  off_ms_ff;
   logic [31:0]  blk_s_ff;
   logic         off_ok_ff;

   logic [CNT_W-1:0]    en_cnt;
   logic                any_match;
   logic [MAX_ON_W-1:0] blk;
   logic signed [MAX_ON_W+1:0] off_raw;
   logic [MAX_ON_W-1:0] off_min;
   logic                fire;
   logic [1:0]          cmd;
   logic [1:0]          ev;

   always_comb begin
      rsif_timer_type t;
      en_cnt    = '0;
      any_match = 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         t = timer_field(csr.timer_table, i);
         if (t.en) begin
            en_cnt = en_cnt + CNT_W'(1);
            if (t.hour == item_ff.hour && t.minute == item_ff.minute) begin
               any_match = 1'b1;
            end
         end
      end
   end

   assign blk     = (csr.max_on_minutes == '0) ? ASSUMED_BLOCK : csr.max_on_minutes;
   assign off_raw = $signed({2'b00, day_quota(en_cnt)}) - $signed({2'b00, blk});
   assign off_min = (off_raw < $signed({2'b00, MIN_OFF})) ? MIN_OFF
                                                           : off_raw[MAX_ON_W-1:0];

   always_comb begin
      fb_in = fb_ff;
      cmd   = CMD_NONE;
      ev    = EVT_NONE;
      fire  = 1'b0;
      if (!item_ff.clock_valid) begin
         if (en_cnt != '0 && csr.fallback_enabled && grace_ok_ff) begin
            fb_in = 1'b1;
            if (!fb_ff) begin
               ev = EVT_LOST;
            end
            if (item_ff.relay_on) begin
               if (csr.max_on_minutes == '0 && item_ff.on_seconds >= blk_s_ff) begin
                  cmd = CMD_OFF;
               end
            end else if (off_ok_ff) begin
               cmd = CMD_ON;
            end
         end
      end else begin
         if (fb_ff) begin
            fb_in = 1'b0;
            ev    = EVT_RESUME;
         end
         if (!(item_ff.hour == fired_hour_ff && item_ff.minute == fired_minute_ff &&
               item_ff.day_of_year == fired_day_ff) &&
             !(item_ff.cutoff_valid && !res.ge) &&
             !item_ff.relay_on && any_match) begin
            fire = 1'b1;
            cmd  = CMD_ON;
         end
      end
   end

   always_comb begin
      op       = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_GRACE;
            end
         end
         ST_GRACE: begin
            op.issue = 1'b1;
            op.a     = item_ff.now_ms;
            op.b     = boot_ff;
            op.c     = GRACE_MS;
            state_in = ST_MOFF;
         end
         ST_MOFF: begin
            op.issue = 1'b1;
            op.mul   = 1'b1;
            op.a     = {{(32 - MAX_ON_W){1'b0}}, off_min};
            op.b     = {{(32 - MUL_B_W){1'b0}}, MS_PER_MIN};
            state_in = ST_MBLK;
         end
         ST_MBLK: begin
            op.issue = 1'b1;
            op.mul   = 1'b1;
            op.a     = {{(32 - MAX_ON_W){1'b0}}, blk};
            op.b     = {{(32 - MUL_B_W){1'b0}}, SEC_PER_MIN};
            state_in = ST_OFFC;
         end
         ST_OFFC: begin
            op.issue = 1'b1;
            op.a     = item_ff.now_ms;
            op.b     = off_since_ff;
            op.c     = off_ms_ff;
            state_in = ST_CUT;
         end
         ST_CUT: begin
            op.issue = 1'b1;
            op.a     = item_ff.now_ms;
            op.b     = item_ff.cutoff_ms;
            op.c     = GUARD_MS;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE) && out_free;

   assign rsp.relay_cmd     = cmd;
   assign rsp.timer_fired   = fire;
   assign rsp.mode_event    = ev;
   assign rsp.interval_mode = fb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         started_ff      <= 1'b0;
         boot_ff         <= '0;
         prev_ff         <= 1'b0;
         off_since_ff    <= '0;
         fb_ff           <= 1'b0;
         fired_hour_ff   <= '1;
         fired_minute_ff <= '1;
         fired_day_ff    <= '1;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && accept) begin
            started_ff <= 1'b1;
            prev_ff    <= req.relay_on;
            if (!started_ff) begin
               boot_ff <= req.now_ms;
            end
            if (!started_ff || (prev_ff && !req.relay_on)) begin
               off_since_ff <= req.now_ms;
            end
         end
         if (done) begin
            fb_ff <= fb_in;
            if (fire) begin
               fired_hour_ff   <= item_ff.hour;
               fired_minute_ff <= item_ff.minute;
               fired_day_ff    <= item_ff.day_of_year;
            end
         end
      end
   end

   // captured unit results
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         item_ff <= req;
      end
      if (state_ff == ST_MOFF) begin
         grace_ok_ff <= res.ge;
      end
      if (state_ff == ST_MBLK) begin
         off_ms_ff <= res.value;
      end
      if (state_ff == ST_OFFC) begin
         blk_s_ff <= res.value;
      end
      if (state_ff == ST_CUT) begin
         off_ok_ff <= res.ge;
      end
   end

endmodule

// ===== hw/rtl/relay_schedule_with_interval_fallback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_schedule_with_interval_fallback
// Relay scheduler tick processor with clock-less interval fallback.
//
// Each transfer on the req_ channel is one scheduler tick; each tick gives
// exactly one transfer on the rsp_ channel with the relay command, the
// timer-fired flag, the mode event and the interval mode flag.
// Timer table, run limit and fallback enable are written through the csr_
// port. The user must write them only while no tick is in flight; the
// block itself does not enforce this. The result is registered in the
// output register after the states GRACE, MOFF, MBLK, OFFC, CUT and DONE.
// A new tick is not taken before the previous one is through; req_stall
// is high while a tick is being worked: five passes through the one shared
// multiply / subtract-compare unit and the decision state; ticks are taken in the idle state.
// A tick is taken while an earlier result still waits on rsp_stall; its
// result is held back until the output register frees.
// Reset (synchronous) clears the scheduler state and the registers to their
// defaults (fallback enabled) and empties the output register.
// ----------------------------------------------------------------------------
module relay_schedule_with_interval_fallback (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rsif_pkg::rsif_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rsif_pkg::rsif_rsp_type              rsp_data,
   input  logic                                csr_write_en,
   input  logic [rsif_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsif_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rsif_pkg::*;

   rsif_csr_type csr_ff;
   logic         rsp_valid_ff;
   rsif_rsp_type rsp_data_ff;
   logic         accept;
   logic         out_free;
   logic         busy;
   logic         done;
   rsif_rsp_type result;
   rsif_op_type  op;
   rsif_res_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.timer_table      <= '0;
         csr_ff.max_on_minutes   <= '0;
         csr_ff.fallback_enabled <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIMERS: begin
               csr_ff.timer_table <= csr_data[TABLE_W-1:0];
            end
            CSR_MAX_ON: begin
               csr_ff.max_on_minutes <= csr_data[MAX_ON_W-1:0];
            end
            CSR_FALLBACK: begin
               csr_ff.fallback_enabled <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   rsif_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .csr      (csr_ff),
      .out_free (out_free),
      .busy     (busy),
      .done     (done),
      .rsp      (result),
      .op       (op),
      .res      (res)
   );

   rsif_unit u_unit (
      .clock (clock),
      .op    (op),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rsif_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsif_checker
// Port-level checks for the relay scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rsif_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsif_pkg::rsif_rsp_type rsp_data
);
   import rsif_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("tick taken while previous tick in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_fired_means_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.timer_fired) |->
      (rsp_data.relay_cmd == CMD_ON && !rsp_data.interval_mode))
      else $error("timer fired without switch-on in schedule mode");

   a_lost_means_interval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mode_event == EVT_LOST) |-> rsp_data.interval_mode)
      else $error("interval entry event without interval mode");

endmodule

bind relay_schedule_with_interval_fallback rsif_checker u_rsif_checker (.*);
